FILE: rtl/grid_ray_traversal_assert.svh
// ----------------------------------------------------------------------------
// grid_ray_traversal_assert
// assertion macros shared by the checker; clk and arst_n must be in scope
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_TRAVERSAL_ASSERT_SVH
`define GRID_RAY_TRAVERSAL_ASSERT_SVH

// checked only while out of reset
`define GRT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define GRT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/grt_pkg.sv
// ----------------------------------------------------------------------------
// grt_pkg
// widths, codes and control types of the grid ray traversal block
// ----------------------------------------------------------------------------
package grt_pkg;

	localparam int POS_W      = 21;
	localparam int FRAC_W     = 16;
	localparam int COL_W      = 5;
	localparam int CODE_W     = 4;
	localparam int DIR_W      = 16;
	localparam int MAG_W      = 16;
	localparam int QUO_W      = 32;
	localparam int DIV_CNT_W  = $clog2(QUO_W);
	localparam int F_W        = FRAC_W + 1;
	localparam int PROD_W     = F_W + QUO_W;
	localparam int SIDE_W     = QUO_W + 1;
	localparam int DIST_W     = 22;
	localparam int CFG_IDX_W  = 1;

	localparam logic [DIST_W-1:0] DIST_MAX     = 22'h3F_FFFF;
	localparam logic [QUO_W-1:0]  STEP_SAT     = 32'hFFFF_FFFF;
	localparam logic [F_W-1:0]    ONE_Q16      = 17'h1_0000;
	localparam logic [POS_W-1:0]  VIEWER_RESET = 21'd98304;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_X = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_Y = 1'b1;

	typedef struct packed {
		logic clear;
		logic wr_cell;
		logic start_cast;
		logic load_setup;
		logic step;
		logic check;
		logic load_out;
	} grt_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic oob;
		logic wall_nz;
		logic steps_last;
		logic out_busy;
	} grt_status_t;

endpackage

FILE: rtl/grt_channels.sv
// ----------------------------------------------------------------------------
// grt_channels
// valid/ready channels for request items, result items and config writes
// ----------------------------------------------------------------------------
interface grt_req_if import grt_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic [COL_W-1:0]         cell_col;
	logic [COL_W-1:0]         cell_row;
	logic [CODE_W-1:0]        cell_code;
	logic signed [DIR_W-1:0]  dir_x;
	logic signed [DIR_W-1:0]  dir_y;

	modport source(output valid, opcode, cell_col, cell_row, cell_code, dir_x, dir_y,
		input ready);
	modport sink(input valid, opcode, cell_col, cell_row, cell_code, dir_x, dir_y,
		output ready);
endinterface

interface grt_rsp_if import grt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              hit;
	logic              side;
	logic [CODE_W-1:0] wall_type;
	logic [DIST_W-1:0] distance;

	modport source(output valid, hit, side, wall_type, distance, input ready);
	modport sink(input valid, hit, side, wall_type, distance, output ready);
endinterface

interface grt_cfg_if import grt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [POS_W-1:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/grid_ray_traversal.sv
// ----------------------------------------------------------------------------
// grid_ray_traversal: dda ray cast over a GRID_DIM x GRID_DIM grid of wall codes
// write item: stores a cell code; cast item: bit-serial reciprocal, then dda steps, each followed by a check
// no new item is taken until the cast's result is loaded into the result register; steps <= MAX_STEPS
// reset clears the grid store in a pass over all GRID_DIM * GRID_DIM cells, no item taken
// ----------------------------------------------------------------------------
module grid_ray_traversal import grt_pkg::*; #(
	parameter int GRID_DIM  = 32,
	parameter int MAX_STEPS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	grt_req_if.sink   req,
	grt_rsp_if.source rsp,
	grt_cfg_if.sink   cfg
);

	grt_cmd_t    cmd;
	grt_status_t status;
	logic        in_ready;

	assign req.ready = in_ready;
	assign cfg.ready = 1'b1;

	grt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_opcode (req.opcode),
		.in_ready  (in_ready),
		.status    (status),
		.cmd       (cmd)
	);

	grt_datapath #(
		.GRID_DIM  (GRID_DIM),
		.MAX_STEPS (MAX_STEPS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_wr    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.cell_col  (req.cell_col),
		.cell_row  (req.cell_row),
		.cell_code (req.cell_code),
		.dir_x     (req.dir_x),
		.dir_y     (req.dir_y),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.hit       (rsp.hit),
		.side      (rsp.side),
		.wall_type (rsp.wall_type),
		.distance  (rsp.distance)
	);

endmodule

FILE: rtl/grt_recip.sv
// ----------------------------------------------------------------------------
// grt_recip
// restoring divider, one quotient bit per cycle, computes 2^31 / mag
// ----------------------------------------------------------------------------
module grt_recip import grt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] mag,
	output logic             done,
	output logic [QUO_W-1:0] quo
);

	logic                 run_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0]     mag_q;
	logic [MAG_W-1:0]     rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic [MAG_W:0]       trial;
	logic                 ge;

	// dividend is a single one in its top bit
	assign trial = {rem_q, (cnt_q == DIV_CNT_W'(QUO_W - 1))};
	assign ge    = trial >= {1'b0, mag_q};
	assign done  = run_q && (cnt_q == '0);
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= DIV_CNT_W'(QUO_W - 1);
		end else if (run_q) begin
			if (cnt_q == '0) begin
				run_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? MAG_W'(trial - {1'b0, mag_q}) : trial[MAG_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

endmodule

FILE: rtl/grt_datapath.sv
// ----------------------------------------------------------------------------
// grt_datapath
// viewer registers, grid store, reciprocal units, dda walk and result register
// ----------------------------------------------------------------------------
module grt_datapath import grt_pkg::*; #(
	parameter int GRID_DIM  = 32,
	parameter int MAX_STEPS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  grt_cmd_t                cmd,
	output grt_status_t             status,
	input  logic                    cfg_wr,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [POS_W-1:0]        cfg_data,
	input  logic [COL_W-1:0]        cell_col,
	input  logic [COL_W-1:0]        cell_row,
	input  logic [CODE_W-1:0]       cell_code,
	input  logic signed [DIR_W-1:0] dir_x,
	input  logic signed [DIR_W-1:0] dir_y,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic                    hit,
	output logic                    side,
	output logic [CODE_W-1:0]       wall_type,
	output logic [DIST_W-1:0]       distance
);

	localparam int DEPTH   = GRID_DIM * GRID_DIM;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int IDX_W   = $clog2(GRID_DIM);
	localparam int COORD_W = $clog2((GRID_DIM > 32) ? GRID_DIM : 32) + 2;
	localparam int CNT_W   = $clog2(MAX_STEPS + 1);
	localparam int SUM_W   = SIDE_W + CNT_W;

	logic [POS_W-1:0]   viewer_x_q, viewer_y_q;
	logic [CODE_W-1:0]  mem [DEPTH];
	logic [CODE_W-1:0]  rd_q;
	logic [ADDR_W-1:0]  clr_addr_q;
	logic [ADDR_W-1:0]  waddr, raddr, cell_addr;
	logic [CODE_W-1:0]  wdata;
	logic               we, cell_ok;

	logic [MAG_W-1:0]   mag_x, mag_y;
	logic [QUO_W-1:0]   quo_x, quo_y;
	logic               done_x, done_y;
	logic               neg_x_q, neg_y_q, zero_x_q, zero_y_q;
	logic [F_W-1:0]     f_x, f_y;
	logic [PROD_W-1:0]  prod_x, prod_y;

	logic [QUO_W-1:0]   delta_x_q, delta_y_q;
	logic [SUM_W-1:0]   side_x_q, side_y_q, dist_q;
	logic [COORD_W-1:0] col_q, row_q, col_nx, row_nx;
	logic [CNT_W-1:0]   n_q;
	logic               pick_x, oob_nx, oob_q, side_q;
	logic               hit_q;
	logic [CODE_W-1:0]  wall_q;

	logic               out_valid_q, out_hit_q, out_side_q;
	logic [CODE_W-1:0]  out_wall_q;
	logic [DIST_W-1:0]  out_dist_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			viewer_x_q <= VIEWER_RESET;
			viewer_y_q <= VIEWER_RESET;
		end else if (cfg_wr) begin
			if (cfg_index == CFG_VIEWER_X) begin
				viewer_x_q <= cfg_data;
			end else if (cfg_index == CFG_VIEWER_Y) begin
				viewer_y_q <= cfg_data;
			end
		end
	end

	// grid store
	assign cell_ok   = (int'(cell_col) < GRID_DIM) && (int'(cell_row) < GRID_DIM);
	assign cell_addr = ADDR_W'(int'(cell_row) * GRID_DIM + int'(cell_col));
	assign we        = cmd.clear || (cmd.wr_cell && cell_ok);
	assign waddr     = cmd.clear ? clr_addr_q : cell_addr;
	assign wdata     = cmd.clear ? '0 : cell_code;
	assign raddr     = ADDR_W'(int'(row_nx[IDX_W-1:0]) * GRID_DIM + int'(col_nx[IDX_W-1:0]));

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	// reciprocal step distances
	assign mag_x = dir_x[DIR_W-1] ? MAG_W'(~dir_x) + MAG_W'(1) : MAG_W'(dir_x);
	assign mag_y = dir_y[DIR_W-1] ? MAG_W'(~dir_y) + MAG_W'(1) : MAG_W'(dir_y);

	grt_recip u_recip_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_cast),
		.mag    (mag_x),
		.done   (done_x),
		.quo    (quo_x)
	);

	grt_recip u_recip_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_cast),
		.mag    (mag_y),
		.done   (done_y),
		.quo    (quo_y)
	);

	always_ff @(posedge clk) begin
		if (cmd.start_cast) begin
			neg_x_q  <= dir_x[DIR_W-1];
			neg_y_q  <= dir_y[DIR_W-1];
			zero_x_q <= (dir_x == '0);
			zero_y_q <= (dir_y == '0);
		end
	end

	// first side distances
	assign f_x = neg_x_q ? {1'b0, viewer_x_q[FRAC_W-1:0]}
		: ONE_Q16 - {1'b0, viewer_x_q[FRAC_W-1:0]};
	assign f_y = neg_y_q ? {1'b0, viewer_y_q[FRAC_W-1:0]}
		: ONE_Q16 - {1'b0, viewer_y_q[FRAC_W-1:0]};
	assign prod_x = PROD_W'(f_x) * PROD_W'(quo_x);
	assign prod_y = PROD_W'(f_y) * PROD_W'(quo_y);

	// one dda step
	assign pick_x = !zero_x_q && (zero_y_q || (side_x_q < side_y_q));

	always_comb begin
		col_nx = col_q;
		row_nx = row_q;
		if (pick_x) begin
			col_nx = neg_x_q ? col_q - COORD_W'(1) : col_q + COORD_W'(1);
		end else begin
			row_nx = (neg_y_q || zero_y_q) ? row_q - COORD_W'(1) : row_q + COORD_W'(1);
		end
	end

	// negative coordinates wrap to large unsigned values
	assign oob_nx = (col_nx >= COORD_W'(GRID_DIM)) || (row_nx >= COORD_W'(GRID_DIM));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (cmd.load_setup) begin
			n_q <= '0;
		end else if (cmd.step) begin
			n_q <= n_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_setup) begin
			delta_x_q <= zero_x_q ? STEP_SAT : quo_x;
			delta_y_q <= zero_y_q ? STEP_SAT : quo_y;
			side_x_q  <= zero_x_q ? SUM_W'(STEP_SAT) : SUM_W'(prod_x[PROD_W-1:FRAC_W]);
			side_y_q  <= zero_y_q ? SUM_W'(STEP_SAT) : SUM_W'(prod_y[PROD_W-1:FRAC_W]);
			col_q     <= COORD_W'(viewer_x_q[POS_W-1:FRAC_W]);
			row_q     <= COORD_W'(viewer_y_q[POS_W-1:FRAC_W]);
			dist_q    <= '0;
			side_q    <= 1'b0;
		end else if (cmd.step) begin
			if (pick_x) begin
				dist_q   <= side_x_q;
				side_x_q <= side_x_q + SUM_W'(delta_x_q);
			end else begin
				dist_q   <= side_y_q;
				side_y_q <= side_y_q + SUM_W'(delta_y_q);
			end
			side_q <= !pick_x;
			col_q  <= col_nx;
			row_q  <= row_nx;
			oob_q  <= oob_nx;
		end
		if (cmd.check) begin
			hit_q  <= !oob_q && (rd_q != '0);
			wall_q <= (!oob_q && (rd_q != '0)) ? rd_q - CODE_W'(1) : '0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_hit_q  <= hit_q;
			out_side_q <= side_q;
			out_wall_q <= wall_q;
			out_dist_q <= (dist_q > SUM_W'(DIST_MAX)) ? DIST_MAX : dist_q[DIST_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = out_hit_q;
	assign side      = out_side_q;
	assign wall_type = out_wall_q;
	assign distance  = out_dist_q;

	assign status.clr_last   = (clr_addr_q == ADDR_W'(DEPTH - 1));
	assign status.div_done   = done_x && done_y;
	assign status.oob        = oob_q;
	assign status.wall_nz    = (rd_q != '0);
	assign status.steps_last = (n_q == CNT_W'(MAX_STEPS));
	assign status.out_busy   = out_valid_q && !out_ready;

endmodule

FILE: rtl/grt_ctrl.sv
// ----------------------------------------------------------------------------
// grt_ctrl
// sequencer for grid clear, cell writes and ray casts
// ----------------------------------------------------------------------------
module grt_ctrl import grt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_opcode,
	output logic        in_ready,
	input  grt_status_t status,
	output grt_cmd_t    cmd
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_SETUP  = 3'd3;
	localparam logic [2:0] ST_STEP   = 3'd4;
	localparam logic [2:0] ST_CHECK  = 3'd5;
	localparam logic [2:0] ST_FINISH = 3'd6;

	logic [2:0] state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clr_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_opcode == OP_CAST) begin
						cmd.start_cast = 1'b1;
						state_nx       = ST_DIV;
					end else begin
						cmd.wr_cell = 1'b1;
					end
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_nx = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.load_setup = 1'b1;
				state_nx       = ST_STEP;
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_nx = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				if (status.oob || status.wall_nz || status.steps_last) begin
					state_nx = ST_FINISH;
				end else begin
					state_nx = ST_STEP;
				end
			end
			ST_FINISH: begin
				if (!status.out_busy) begin
					cmd.load_out = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/grt_checker.sv
// ----------------------------------------------------------------------------
// grt_checker
// port-level checks of the grid ray traversal block, bound to the top level
// ----------------------------------------------------------------------------
`include "grid_ray_traversal_assert.svh"

module grt_checker import grt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic              hit,
	input logic              side,
	input logic [CODE_W-1:0] wall_type,
	input logic [DIST_W-1:0] distance
);

	// a stalled result item holds
	`GRT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit) && $stable(side) && $stable(wall_type) && $stable(distance), "result item changed while stalled")

	`GRT_ASSERT(a_miss_wall_zero, rsp_valid && !hit |-> wall_type == '0, "wall type nonzero without a hit")

	`GRT_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !rsp_valid && !req_ready, "block active in reset")

endmodule

bind grid_ray_traversal grt_checker u_grt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.hit       (rsp.hit),
	.side      (rsp.side),
	.wall_type (rsp.wall_type),
	.distance  (rsp.distance)
);
